FILE: rtl/core/nbihs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-band IHS transform package
// Shared widths, configuration register codes, the pipeline step record and
// the arctangent table used by the angle pipeline.
// ----------------------------------------------------------------------------
package nbihs_pkg;

    localparam int MAX_BANDS        = 4;
    localparam int LANES            = 4;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int TAB_LEN          = 24;
    localparam int BAND_LIMIT       = (MAX_BANDS < LANES) ? MAX_BANDS : LANES;

    localparam int PIX_W    = 8;
    localparam int CNT_W    = 3;
    localparam int REG_W    = 32;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int PRE_SH   = 24;
    localparam int CW       = SUM_W + PRE_SH + 2;
    localparam int ZW       = 35;
    localparam int QUO_W    = 16;
    localparam int HUE_W    = 16;
    localparam int ANGLE_W  = 33;
    localparam int PHI_W    = 31;
    localparam int CFG_IDX_W = 3;

    localparam int PIPE_STEPS = (ANGLE_ITERATIONS > QUO_W) ? ANGLE_ITERATIONS : QUO_W;
    localparam int STEP_W     = $clog2(PIPE_STEPS);

    localparam logic [REG_W-1:0] COEF_RESET  = 32'h0000_4000;
    localparam logic [CNT_W-1:0] COUNT_RESET = 3'd3;
    localparam logic [HUE_W-1:0] HUE_MAX     = 16'd65279;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAND_COUNT = 3'd0,
        REG_BAND0_COEF = 3'd1,
        REG_BAND1_COEF = 3'd2,
        REG_BAND2_COEF = 3'd3,
        REG_BAND3_COEF = 3'd4
    } cfg_idx_t;

    // One slot of the combined CORDIC / saturation divider pipeline.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 c_neg;
        logic                 s_neg;
        logic                 y_zero;
        logic [PIX_W-1:0]     mx;
        logic [PIX_W-1:0]     rem;
        logic [QUO_W-1:0]     num;
        logic [QUO_W-1:0]     quo;
    } step_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/nbihs_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-band IHS band lane
// Forms one band's excess over the pixel minimum and weights it by the band's
// sine and cosine, with the two products registered.
// ----------------------------------------------------------------------------
module nbihs_lane (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   active,
    input  logic [nbihs_pkg::PIX_W-1:0]            value,
    input  logic [nbihs_pkg::PIX_W-1:0]            mn,
    input  logic [nbihs_pkg::REG_W-1:0]            coef,
    output logic signed [nbihs_pkg::PROD_W-1:0]    prod_s_reg,
    output logic signed [nbihs_pkg::PROD_W-1:0]    prod_c_reg
);
    import nbihs_pkg::*;

    logic [PIX_W-1:0]         diff;
    logic signed [PROD_W-1:0] prod_s_next;
    logic signed [PROD_W-1:0] prod_c_next;

    // Unused lanes contribute nothing to the sums.
    assign diff        = active ? (value - mn) : '0;
    assign prod_s_next = $signed({1'b0, diff}) * $signed(coef[REG_W-1:COEF_W]);
    assign prod_c_next = $signed({1'b0, diff}) * $signed(coef[COEF_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_s_reg <= prod_s_next;
            prod_c_reg <= prod_c_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/nbihs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-band IHS pipeline step
// One vectoring CORDIC rotation and one restoring division bit for the
// saturation quotient, followed by the stage register.
// ----------------------------------------------------------------------------
module nbihs_step (
    input  logic                          clk,
    input  logic                          en,
    input  logic [nbihs_pkg::STEP_W-1:0]  step,
    input  nbihs_pkg::step_t              d_in,
    output nbihs_pkg::step_t              d_reg
);
    import nbihs_pkg::*;

    step_t                d_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] at;
    logic [PIX_W:0]       r9;
    logic                 qbit;
    logic                 do_rot;
    logic                 do_div;

    assign do_rot = (int'(step) < ANGLE_ITERATIONS) && (int'(step) < TAB_LEN);
    assign do_div = int'(step) < QUO_W;
    assign xs     = $signed(d_in.x) >>> step;
    assign ys     = $signed(d_in.y) >>> step;
    assign at     = $signed({{(ZW-32){1'b0}}, atan_entry(5'(step))});
    assign r9     = {d_in.rem, d_in.num[QUO_W-1]};
    assign qbit   = r9 >= {1'b0, d_in.mx};

    always_comb
    begin
        d_next = d_in;
        if (do_rot)
        begin
            if (!d_in.y[CW-1])
            begin
                d_next.x = d_in.x + ys;
                d_next.y = d_in.y - xs;
                d_next.z = d_in.z + at;
            end
            else
            begin
                d_next.x = d_in.x - ys;
                d_next.y = d_in.y + xs;
                d_next.z = d_in.z - at;
            end
        end
        if (do_div)
        begin
            d_next.rem = qbit ? PIX_W'(r9 - {1'b0, d_in.mx}) : r9[PIX_W-1:0];
            d_next.num = {d_in.num[QUO_W-2:0], 1'b0};
            d_next.quo = {d_in.quo[QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/n_band_ihs_transform_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-band IHS transform
// Converts one pixel of up to four 8-bit bands into intensity, hue and
// saturation in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block takes one pixel transfer per clock while the output side does
// not stall and returns one result per pixel, in order, through its stages
// (input register, min/max, four parallel multiply lanes, the
// sum merge, sixteen combined CORDIC/divider steps, angle select and output
// register). The latency is set by the sixteen-step vectoring CORDIC chain,
// which runs beside the bit-per-step saturation divider. Every stage holds
// its contents while the next stage is held full, so stalls on the result side
// fill bubbles first and only then stop input transfers. Configuration writes
// take effect at once and are meant to happen only while the pipe is empty.
// Intensity is the maximum of the bands in use; hue is the angle of the
// weighted (cosine, sine) sum mapped to 0..255 in Q8.8; saturation is
// 255*(1-min/max) in Q8.8, zero for an all-black pixel.
// ----------------------------------------------------------------------------
module n_band_ihs_transform_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nbihs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nbihs_pkg::REG_W-1:0]         cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [nbihs_pkg::PIX_W-1:0]         band0,
    input  logic [nbihs_pkg::PIX_W-1:0]         band1,
    input  logic [nbihs_pkg::PIX_W-1:0]         band2,
    input  logic [nbihs_pkg::PIX_W-1:0]         band3,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [nbihs_pkg::PIX_W-1:0]         intensity,
    output logic [nbihs_pkg::HUE_W-1:0]         hue_q8,
    output logic [nbihs_pkg::QUO_W-1:0]         saturation_q8
);
    import nbihs_pkg::*;

    localparam int ST_IN  = 0;
    localparam int ST_MM  = 1;
    localparam int ST_LN  = 2;
    localparam int ST_SUM = 3;
    localparam int ST_CS  = 4;
    localparam int ST_ANG = ST_CS + PIPE_STEPS;
    localparam int ST_OUT = ST_ANG + 1;
    localparam int NSTG   = ST_OUT + 1;

    // Configuration registers.
    logic [CNT_W-1:0] band_count_reg;
    logic [REG_W-1:0] coef_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_count_reg <= COUNT_RESET;
            for (int b = 0; b < LANES; b++)
            begin
                coef_reg[b] <= COEF_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BAND_COUNT: band_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_BAND0_COEF: coef_reg[0]    <= cfg_wdata;
                REG_BAND1_COEF: coef_reg[1]    <= cfg_wdata;
                REG_BAND2_COEF: coef_reg[2]    <= cfg_wdata;
                REG_BAND3_COEF: coef_reg[3]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage valid bits and the load enables. A stage loads when it is empty
    // or when its contents move on in the same cycle.
    logic [NSTG-1:0] valid_reg;
    logic [NSTG:0]   en;

    always_comb
    begin
        en[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign in_ready  = en[ST_IN];
    assign out_valid = valid_reg[ST_OUT];

    // Input register with the clamped band count.
    logic [PIX_W-1:0] band_reg [LANES];
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;

    always_comb
    begin
        n_next = band_count_reg;
        if (n_next == '0)
        begin
            n_next = CNT_W'(1);
        end
        if (n_next > CNT_W'(BAND_LIMIT))
        begin
            n_next = CNT_W'(BAND_LIMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            band_reg[0] <= band0;
            band_reg[1] <= band1;
            band_reg[2] <= band2;
            band_reg[3] <= band3;
            n_reg       <= n_next;
        end
    end

    // Minimum and maximum over the bands in use.
    logic [LANES-1:0] act_next;
    logic [PIX_W-1:0] mx_next;
    logic [PIX_W-1:0] mn_next;
    logic [LANES-1:0] act_reg;
    logic [PIX_W-1:0] mx_mm_reg;
    logic [PIX_W-1:0] mn_mm_reg;
    logic [PIX_W-1:0] band_mm_reg [LANES];

    always_comb
    begin
        mx_next = '0;
        mn_next = '1;
        for (int b = 0; b < LANES; b++)
        begin
            act_next[b] = CNT_W'(b) < n_reg;
            if (act_next[b] && band_reg[b] > mx_next)
            begin
                mx_next = band_reg[b];
            end
            if (act_next[b] && band_reg[b] < mn_next)
            begin
                mn_next = band_reg[b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MM])
        begin
            act_reg     <= act_next;
            mx_mm_reg   <= mx_next;
            mn_mm_reg   <= mn_next;
            band_mm_reg <= band_reg;
        end
    end

    // Parallel weighting lanes, one per band.
    logic signed [PROD_W-1:0] prod_s [LANES];
    logic signed [PROD_W-1:0] prod_c [LANES];
    logic [PIX_W-1:0]         mx_ln_reg;
    logic [PIX_W-1:0]         mn_ln_reg;

    for (genvar b = 0; b < LANES; b++)
    begin : g_lane
        nbihs_lane u_lane (
            .clk        (clk),
            .en         (en[ST_LN]),
            .active     (act_reg[b]),
            .value      (band_mm_reg[b]),
            .mn         (mn_mm_reg),
            .coef       (coef_reg[b]),
            .prod_s_reg (prod_s[b]),
            .prod_c_reg (prod_c[b])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_LN])
        begin
            mx_ln_reg <= mx_mm_reg;
            mn_ln_reg <= mn_mm_reg;
        end
    end

    // Merge: the lane products are summed into the sine and cosine sums.
    logic signed [SUM_W-1:0] s_next;
    logic signed [SUM_W-1:0] c_next;
    logic signed [SUM_W-1:0] s_sum_reg;
    logic signed [SUM_W-1:0] c_sum_reg;
    logic [PIX_W-1:0]        mx_sum_reg;
    logic [PIX_W-1:0]        mn_sum_reg;

    always_comb
    begin
        s_next = '0;
        c_next = '0;
        for (int b = 0; b < LANES; b++)
        begin
            s_next = s_next + SUM_W'(prod_s[b]);
            c_next = c_next + SUM_W'(prod_c[b]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            s_sum_reg  <= s_next;
            c_sum_reg  <= c_next;
            mx_sum_reg <= mx_ln_reg;
            mn_sum_reg <= mn_ln_reg;
        end
    end

    // Seed of the CORDIC and divider pipeline. A zero cosine sum counts as
    // one LSB. The dividend is 65280 times the band spread.
    step_t                 seed;
    logic [SUM_W-1:0]      ax;
    logic [SUM_W-1:0]      ay;
    logic [PIX_W-1:0]      spread;
    logic [PIX_W+QUO_W-1:0] dividend;

    always_comb
    begin
        ax = c_sum_reg[SUM_W-1] ? SUM_W'(-c_sum_reg) : c_sum_reg;
        if (ax == '0)
        begin
            ax = SUM_W'(1);
        end
        ay       = s_sum_reg[SUM_W-1] ? SUM_W'(-s_sum_reg) : s_sum_reg;
        spread   = mx_sum_reg - mn_sum_reg;
        dividend = {spread, 16'h0000} - {8'h00, spread, 8'h00};

        seed        = '0;
        seed.x      = $signed({2'b00, ax, {PRE_SH{1'b0}}});
        seed.y      = $signed({2'b00, ay, {PRE_SH{1'b0}}});
        seed.c_neg  = c_sum_reg[SUM_W-1];
        seed.s_neg  = s_sum_reg[SUM_W-1];
        seed.y_zero = (s_sum_reg == '0);
        seed.mx     = mx_sum_reg;
        seed.rem    = dividend[PIX_W+QUO_W-1:QUO_W];
        seed.num    = dividend[QUO_W-1:0];
    end

    step_t st_in  [PIPE_STEPS];
    step_t st_out [PIPE_STEPS];

    for (genvar k = 0; k < PIPE_STEPS; k++)
    begin : g_step
        if (k == 0)
        begin : g_first
            assign st_in[k] = seed;
        end
        else
        begin : g_chain
            assign st_in[k] = st_out[k-1];
        end

        nbihs_step u_step (
            .clk   (clk),
            .en    (en[ST_CS+k]),
            .step  (STEP_W'(k)),
            .d_in  (st_in[k]),
            .d_reg (st_out[k])
        );
    end

    // Quadrant mapping of the first-quadrant angle.
    step_t                last;
    logic [PHI_W-1:0]     phi;
    logic [ANGLE_W-1:0]   angle_next;
    logic [ANGLE_W-1:0]   angle_reg;
    logic [PIX_W-1:0]     mx_ang_reg;
    logic [QUO_W-1:0]     sat_ang_reg;

    assign last = st_out[PIPE_STEPS-1];

    always_comb
    begin
        if (last.y_zero || last.z[ZW-1])
        begin
            phi = '0;
        end
        else if (last.z > $signed(ZW'(1) <<< 30))
        begin
            phi = PHI_W'(1) << 30;
        end
        else
        begin
            phi = last.z[PHI_W-1:0];
        end

        case ({last.c_neg, last.s_neg})
            2'b00:   angle_next = {2'b00, phi};
            2'b01:   angle_next = {1'b1, 32'h0} - {2'b00, phi};
            2'b10:   angle_next = {2'b01, 31'h0} - {2'b00, phi};
            default: angle_next = {2'b01, 31'h0} + {2'b00, phi};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ANG])
        begin
            angle_reg   <= angle_next;
            mx_ang_reg  <= last.mx;
            sat_ang_reg <= (last.mx == '0) ? '0 : last.quo;
        end
    end

    // Hue is floor(angle * 255 / 2^24), saturated below a full turn.
    logic [ANGLE_W+7:0] hue_prod;
    logic [HUE_W:0]     hue_wide;
    logic [HUE_W-1:0]   hue_next;
    logic [PIX_W-1:0]   intensity_reg;
    logic [HUE_W-1:0]   hue_reg;
    logic [QUO_W-1:0]   sat_reg;

    always_comb
    begin
        hue_prod = {angle_reg, 8'h00} - {8'h00, angle_reg};
        hue_wide = hue_prod[ANGLE_W+7:24];
        hue_next = (hue_wide > {1'b0, HUE_MAX}) ? HUE_MAX : hue_wide[HUE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            intensity_reg <= mx_ang_reg;
            hue_reg       <= hue_next;
            sat_reg       <= sat_ang_reg;
        end
    end

    assign intensity     = intensity_reg;
    assign hue_q8        = hue_reg;
    assign saturation_q8 = sat_reg;

    // A black pixel never shows saturation.
    a_black_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && intensity == '0 |-> saturation_q8 == '0)
        else $error("saturation set on a black pixel");

    // The hue stays below a full turn.
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue_q8 <= HUE_MAX)
        else $error("hue out of range");

    // An empty output stage always lets a new pixel in.
    a_ready_on_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[ST_OUT] |-> in_ready)
        else $error("input stalled with an empty output stage");

    // A stalled result with every stage full stops input transfers.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && valid_reg[ST_ANG] |-> !in_ready || !valid_reg[ST_IN]
        || !(&valid_reg))
        else $error("pipeline advanced into a full stalled stage");

endmodule
`default_nettype wire
